FILE: sv/iipv_pkg.sv
// Package with the shared types, keyword tables and helpers of the image parameter validator.
package iipv_pkg;

  // Kind of path component under check.
  typedef enum logic [1:0] {
    KIND_REGION  = 2'd0,
    KIND_SIZE    = 2'd1,
    KIND_ROT     = 2'd2,
    KIND_QUALFMT = 2'd3
  } kind_t;

  // Keyword identifiers.
  typedef enum logic [3:0] {
    W_COLOR   = 4'd0,
    W_GRAY    = 4'd1,
    W_BITONAL = 4'd2,
    W_DEFAULT = 4'd3,
    W_JPG     = 4'd4,
    W_TIF     = 4'd5,
    W_PNG     = 4'd6,
    W_JP2     = 4'd7,
    W_MAX     = 4'd8,
    W_PCT     = 4'd9,
    W_FULL    = 4'd10,
    W_SQUARE  = 4'd11
  } word_t;

  localparam int WORD_COUNT = 12;

  // Recognizer states. Keyword states sit at 32 plus the keyword id.
  typedef enum logic [5:0] {
    GS_START     = 6'd0,
    GS_DEAD      = 6'd1,
    GS_DONE      = 6'd2,
    GS_DOT       = 6'd3,
    GS_FMT       = 6'd4,
    GS_FSTART    = 6'd5,
    GS_FINT      = 6'd6,
    GS_FDOT      = 6'd7,
    GS_FFRAC     = 6'd8,
    GS_ISTART    = 6'd9,
    GS_IINT      = 6'd10,
    GS_SZBODY    = 6'd11,
    GS_SZW0      = 6'd12,
    GS_SZW       = 6'd13,
    GS_SZCOMMA   = 6'd14,
    GS_SZH0      = 6'd15,
    GS_SZH       = 6'd16,
    GS_KW_COLOR  = 6'd32,
    GS_KW_GRAY   = 6'd33,
    GS_KW_BITON  = 6'd34,
    GS_KW_DEFLT  = 6'd35,
    GS_KW_JPG    = 6'd36,
    GS_KW_TIF    = 6'd37,
    GS_KW_PNG    = 6'd38,
    GS_KW_JP2    = 6'd39,
    GS_KW_MAX    = 6'd40,
    GS_KW_PCT    = 6'd41,
    GS_KW_FULL   = 6'd42,
    GS_KW_SQUARE = 6'd43
  } gstate_t;

  // Keyword text, first character in the top byte, zero padded to seven bytes.
  localparam logic [55:0] WORD_TEXT [WORD_COUNT] = '{
    {"color", 16'h0}, {"gray", 24'h0}, "bitonal", "default",
    {"jpg", 32'h0}, {"tif", 32'h0}, {"png", 32'h0}, {"jp2", 32'h0},
    {"max", 32'h0}, {"pct:", 24'h0}, {"full", 24'h0}, {"square", 8'h0}
  };

  // Character at a position of a keyword.
  function automatic logic [7:0] word_char(logic [3:0] w, logic [2:0] p);
    logic [55:0] s;
    s = '0;
    if (w < 4'(WORD_COUNT)) begin
      s = WORD_TEXT[w] << {p, 3'b000};
    end
    return s[55:48];
  endfunction

  // Length of a keyword.
  function automatic logic [3:0] word_len(logic [3:0] w);
    logic [3:0] n;
    case (w)
      W_COLOR:   n = 4'd5;
      W_GRAY:    n = 4'd4;
      W_BITONAL: n = 4'd7;
      W_DEFAULT: n = 4'd7;
      W_JPG:     n = 4'd3;
      W_TIF:     n = 4'd3;
      W_PNG:     n = 4'd3;
      W_JP2:     n = 4'd3;
      W_MAX:     n = 4'd3;
      W_PCT:     n = 4'd4;
      W_FULL:    n = 4'd4;
      W_SQUARE:  n = 4'd6;
      default:   n = 4'd0;
    endcase
    return n;
  endfunction

  // State entered once a keyword is complete.
  function automatic gstate_t word_next(logic [3:0] w);
    gstate_t g;
    case (w)
      W_COLOR, W_GRAY, W_BITONAL, W_DEFAULT: g = GS_DOT;
      W_PCT:                                 g = GS_FSTART;
      default:                               g = GS_DONE;
    endcase
    return g;
  endfunction

  // Start state of a keyword.
  function automatic gstate_t word_state(word_t w);
    return gstate_t'({2'b10, w});
  endfunction

endpackage

FILE: sv/iipv_req_if.sv
// Request channel: one character of a component per request.
interface iipv_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [1:0] component_kind;
  logic       last_char;
  logic       empty_component;

  modport source (output valid, char_code, component_kind, last_char, empty_component,
                  input ready);
  modport sink   (input valid, char_code, component_kind, last_char, empty_component,
                  output ready);
endinterface

FILE: sv/iipv_res_if.sv
// Result channel: one verdict per finished component.
interface iipv_res_if;
  logic       valid;
  logic       ready;
  logic       is_valid;
  logic [1:0] checked_kind;

  modport source (output valid, is_valid, checked_kind, input ready);
  modport sink   (input valid, is_valid, checked_kind, output ready);
endinterface

FILE: sv/iiif_image_parameter_validator.sv
// Top level of the image parameter validator: streaming grammar check of one path component.
//
// Usage: the req channel carries one character of a component per request together
// with the component kind (region, size, rotation, quality.format), a last-character
// mark and an empty-component mark. The kind is taken from the request that opens a
// component. On the request marked last, the res channel delivers one result:
// is_valid tells whether the whole component matched the grammar of its kind, and
// checked_kind gives the kind that was checked. Requests not marked last give no result.
// Throughput: one request per cycle, sustained, as long as results are taken.
// A request is held in an input register, from which the recognizer steps on it, and
// the result of a component is written to the result register when the request marked
// last advances from the input register. The recognizer step is a single state
// transition, which sets that rate.
// Reset (rst, synchronous) empties both registers and returns the recognizer to the
// start of a component with kind region latched.
// Stall: while a result waits, requests that give no result still flow through; a
// request that ends a component waits in the input register, and req.ready drops
// only once that register is full and cannot advance.
module iiif_image_parameter_validator (
  input logic clk,
  input logic rst,
  iipv_req_if.sink   req,
  iipv_res_if.source res
);
  import iipv_pkg::*;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_char;
  logic [1:0] s1_kind;
  logic       s1_last;
  logic       s1_empty;

  // Recognizer state.
  gstate_t    grammar_state, grammar_state_next;
  logic [2:0] keyword_position, keyword_position_next;
  logic [1:0] number_count, number_count_next;
  logic       confined_flag, confined_flag_next;
  kind_t      kind_latch, kind_latch_next;
  logic       failed_flag, failed_flag_next;

  // Result register.
  logic       out_valid;
  logic       out_is_valid;
  logic [1:0] out_kind;

  logic       out_free;
  logic       proc;
  logic       step_en;
  logic       in_fire;
  logic       verdict;

  // Handshake and advance control.
  assign out_free  = !out_valid || res.ready;
  assign proc      = s1_valid && (!s1_last || out_free);
  assign step_en   = proc && (!s1_empty || s1_last);
  assign req.ready = !s1_valid || proc;
  assign in_fire   = req.valid && req.ready;

  assign res.valid        = out_valid;
  assign res.is_valid     = out_is_valid;
  assign res.checked_kind = out_kind;

  // One recognizer step on the held character.
  always_comb begin
    logic       bad;
    logic       dig;
    logic [3:0] w;
    logic [3:0] pn;
    logic [3:0] len;
    kind_t      kind_eff;

    grammar_state_next    = grammar_state;
    keyword_position_next = keyword_position;
    number_count_next     = number_count;
    confined_flag_next    = confined_flag;
    failed_flag_next      = failed_flag;
    bad                   = 1'b0;
    dig                   = (s1_char >= "0") && (s1_char <= "9");
    w                     = grammar_state[3:0];
    pn                    = {1'b0, keyword_position} + 4'd1;
    len                   = word_len(w);
    kind_eff              = (grammar_state == GS_START) ? kind_t'(s1_kind) : kind_latch;
    kind_latch_next       = kind_eff;

    if (!s1_empty && !failed_flag) begin
      if (grammar_state[5]) begin
        // Keyword matching, one character per step.
        if (w >= 4'(WORD_COUNT) || {1'b0, keyword_position} >= len) begin
          bad = 1'b1;
        end else if (s1_char == word_char(w, keyword_position) ||
                     (w == W_JPG && keyword_position == 3'd2 && s1_char == "2")) begin
          if (pn >= len) begin
            grammar_state_next    = word_next(w);
            keyword_position_next = 3'd0;
          end else begin
            keyword_position_next = pn[2:0];
          end
        end else begin
          bad = 1'b1;
        end
      end else begin
        case (grammar_state)
          GS_START: begin
            keyword_position_next = 3'd1;
            case (kind_eff)
              KIND_REGION: begin
                if (s1_char == "f") grammar_state_next = word_state(W_FULL);
                else if (s1_char == "s") grammar_state_next = word_state(W_SQUARE);
                else if (s1_char == "p") grammar_state_next = word_state(W_PCT);
                else if (dig) begin
                  grammar_state_next    = GS_IINT;
                  keyword_position_next = keyword_position;
                end else bad = 1'b1;
              end
              KIND_SIZE: begin
                keyword_position_next = keyword_position;
                if (s1_char == "^") grammar_state_next = GS_SZBODY;
                else if (s1_char == "m") begin
                  grammar_state_next    = word_state(W_MAX);
                  keyword_position_next = 3'd1;
                end else if (s1_char == "p") begin
                  grammar_state_next    = word_state(W_PCT);
                  keyword_position_next = 3'd1;
                end else if (s1_char == "!") begin
                  confined_flag_next = 1'b1;
                  grammar_state_next = GS_SZW0;
                end else if (s1_char == ",") grammar_state_next = GS_SZH0;
                else if (dig) grammar_state_next = GS_SZW;
                else bad = 1'b1;
              end
              KIND_ROT: begin
                keyword_position_next = keyword_position;
                if (s1_char == "!") grammar_state_next = GS_FSTART;
                else if (dig) grammar_state_next = GS_FINT;
                else bad = 1'b1;
              end
              default: begin
                if (s1_char == "c") grammar_state_next = word_state(W_COLOR);
                else if (s1_char == "g") grammar_state_next = word_state(W_GRAY);
                else if (s1_char == "b") grammar_state_next = word_state(W_BITONAL);
                else if (s1_char == "d") grammar_state_next = word_state(W_DEFAULT);
                else bad = 1'b1;
              end
            endcase
          end
          GS_SZBODY: begin
            if (s1_char == "m") begin
              grammar_state_next    = word_state(W_MAX);
              keyword_position_next = 3'd1;
            end else if (s1_char == "p") begin
              grammar_state_next    = word_state(W_PCT);
              keyword_position_next = 3'd1;
            end else if (s1_char == "!") begin
              confined_flag_next = 1'b1;
              grammar_state_next = GS_SZW0;
            end else if (s1_char == ",") grammar_state_next = GS_SZH0;
            else if (dig) grammar_state_next = GS_SZW;
            else bad = 1'b1;
          end
          GS_DOT: begin
            if (s1_char == ".") grammar_state_next = GS_FMT;
            else bad = 1'b1;
          end
          GS_FMT: begin
            keyword_position_next = 3'd1;
            if (s1_char == "j") grammar_state_next = word_state(W_JPG);
            else if (s1_char == "t") grammar_state_next = word_state(W_TIF);
            else if (s1_char == "p") grammar_state_next = word_state(W_PNG);
            else bad = 1'b1;
          end
          GS_FSTART: begin
            if (dig) grammar_state_next = GS_FINT;
            else bad = 1'b1;
          end
          GS_FINT, GS_FFRAC: begin
            // A comma is only legal between the four numbers of a region.
            if (dig) begin
              grammar_state_next = grammar_state;
            end else if (s1_char == "." && grammar_state == GS_FINT) begin
              grammar_state_next = GS_FDOT;
            end else if (s1_char == "," && kind_eff == KIND_REGION &&
                         number_count != 2'd3) begin
              number_count_next  = number_count + 2'd1;
              grammar_state_next = GS_FSTART;
            end else bad = 1'b1;
          end
          GS_FDOT: begin
            if (dig) grammar_state_next = GS_FFRAC;
            else bad = 1'b1;
          end
          GS_ISTART: begin
            if (dig) grammar_state_next = GS_IINT;
            else bad = 1'b1;
          end
          GS_IINT: begin
            if (dig) begin
              grammar_state_next = GS_IINT;
            end else if (s1_char == "," && kind_eff == KIND_REGION &&
                         number_count != 2'd3) begin
              number_count_next  = number_count + 2'd1;
              grammar_state_next = GS_ISTART;
            end else bad = 1'b1;
          end
          GS_SZW0: begin
            if (dig) grammar_state_next = GS_SZW;
            else bad = 1'b1;
          end
          GS_SZH0: begin
            if (dig) grammar_state_next = GS_SZH;
            else bad = 1'b1;
          end
          GS_SZW: begin
            if (dig) grammar_state_next = GS_SZW;
            else if (s1_char == ",") grammar_state_next = GS_SZCOMMA;
            else bad = 1'b1;
          end
          GS_SZCOMMA, GS_SZH: begin
            if (dig) grammar_state_next = GS_SZH;
            else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
    end

    if (bad) begin
      grammar_state_next = GS_DEAD;
      failed_flag_next   = 1'b1;
    end

    // Verdict on the state reached so far.
    case (grammar_state_next)
      GS_DONE:            verdict = 1'b1;
      GS_FINT, GS_FFRAC:  verdict = (kind_eff != KIND_REGION) || (number_count_next == 2'd3);
      GS_IINT:            verdict = (number_count_next == 2'd3);
      GS_SZCOMMA:         verdict = !confined_flag_next;
      GS_SZH:             verdict = 1'b1;
      default:            verdict = 1'b0;
    endcase
    verdict = verdict && !failed_flag_next;

    // The last character closes the component.
    if (s1_last) begin
      grammar_state_next    = GS_START;
      keyword_position_next = 3'd0;
      number_count_next     = 2'd0;
      confined_flag_next    = 1'b0;
      failed_flag_next      = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_char  <= req.char_code;
      s1_kind  <= req.component_kind;
      s1_last  <= req.last_char;
      s1_empty <= req.empty_component;
    end
  end

  // Recognizer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grammar_state    <= GS_START;
      keyword_position <= 3'd0;
      number_count     <= 2'd0;
      confined_flag    <= 1'b0;
      kind_latch       <= KIND_REGION;
      failed_flag      <= 1'b0;
    end else if (step_en) begin
      grammar_state    <= grammar_state_next;
      keyword_position <= keyword_position_next;
      number_count     <= number_count_next;
      confined_flag    <= confined_flag_next;
      kind_latch       <= kind_latch_next;
      failed_flag      <= failed_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && s1_last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (proc && s1_last) begin
      out_is_valid <= verdict;
      out_kind     <= kind_latch_next;
    end
  end

  // A mismatch always parks the recognizer in the dead state.
  a_fail_dead: assert property (@(posedge clk) disable iff (rst)
    failed_flag |-> grammar_state == GS_DEAD)
    else $error("failed flag set outside the dead state");

  // Outside a mismatch, the keyword position is only set while a keyword is matched.
  a_kw_pos: assert property (@(posedge clk) disable iff (rst)
    keyword_position != 3'd0 |-> grammar_state[5] || failed_flag)
    else $error("keyword position set outside a keyword state");

  // Commas are only counted for a region.
  a_count_region: assert property (@(posedge clk) disable iff (rst)
    number_count != 2'd0 |-> kind_latch == KIND_REGION)
    else $error("number count set for a non-region component");

  // The confined mark only arises in a size component.
  a_confined_size: assert property (@(posedge clk) disable iff (rst)
    confined_flag |-> kind_latch == KIND_SIZE)
    else $error("confined flag set for a non-size component");

  // A closing character advanced into a full result register never happens.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |-> !(proc && s1_last))
    else $error("result overwritten while waiting");

endmodule

FILE: verif/tb_iiif_image_parameter_validator.sv
// Self-checking testbench for the image parameter validator: directed and random components.
module tb_iiif_image_parameter_validator;
  import iipv_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_CHARS  = 780;
  localparam int NOISE_CHARS   = 200;
  localparam int DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic  ok;
    kind_t kind;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  iipv_req_if req_bus ();
  iipv_res_if res_bus ();

  iiif_image_parameter_validator i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .res (res_bus)
  );

  always #4 clk = ~clk;

  // Verdicts still owed by the block, oldest first.
  verdict_t verdicts_due[$];
  verdict_t verdict_seen;
  int unsigned errors = 0;
  int unsigned chars_fed = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;
  bit pace_on = 1'b1;
  bit stall_on = 1'b1;

  // Characters of the component being built.
  logic [7:0] spell[$];

  // Shadow copy of the recognizer state.
  gstate_t    g_state;
  logic [2:0] g_pos;
  logic [1:0] g_commas;
  logic       g_confined;
  kind_t      g_kind;
  logic       g_failed;

  // ---------------------------------------------------------------------------
  // Grammar predictor
  // ---------------------------------------------------------------------------

  function automatic string word_spelling(word_t w);
    case (w)
      W_COLOR:   return "color";
      W_GRAY:    return "gray";
      W_BITONAL: return "bitonal";
      W_DEFAULT: return "default";
      W_JPG:     return "jpg";
      W_TIF:     return "tif";
      W_PNG:     return "png";
      W_JP2:     return "jp2";
      W_MAX:     return "max";
      W_PCT:     return "pct:";
      W_FULL:    return "full";
      W_SQUARE:  return "square";
      default:   return "";
    endcase
  endfunction

  // Qualities are followed by a dot, the percent prefix by a decimal, the rest end.
  function automatic gstate_t word_exit(word_t w);
    case (w)
      W_COLOR, W_GRAY, W_BITONAL, W_DEFAULT: return GS_DOT;
      W_PCT:                                 return GS_FSTART;
      default:                               return GS_DONE;
    endcase
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic clear_component();
    g_state    = GS_START;
    g_pos      = '0;
    g_commas   = '0;
    g_confined = 1'b0;
    g_failed   = 1'b0;
  endtask

  task automatic mark_mismatch();
    g_failed = 1'b1;
    g_state  = GS_DEAD;
  endtask

  task automatic open_word(word_t w);
    g_state = gstate_t'(6'(GS_KW_COLOR + 6'(w)));
    g_pos   = 3'd1;
  endtask

  // A comma inside a region list moves on to the next number.
  task automatic list_comma(gstate_t nxt);
    if (g_kind == KIND_REGION && g_commas < 2'd3) begin
      g_commas = g_commas + 2'd1;
      g_state  = nxt;
    end else begin
      mark_mismatch();
    end
  endtask

  task automatic size_choice(logic [7:0] c);
    if (c == "m") open_word(W_MAX);
    else if (c == "p") open_word(W_PCT);
    else if (c == "!") begin
      g_confined = 1'b1;
      g_state    = GS_SZW0;
    end
    else if (c == ",") g_state = GS_SZH0;
    else if (is_digit(c)) g_state = GS_SZW;
    else mark_mismatch();
  endtask

  // One character through the recognizer.
  task automatic recognize_char(logic [7:0] c);
    word_t w;
    string sp;
    int    p;
    if (g_failed) return;
    if (g_state >= GS_KW_COLOR) begin
      w  = word_t'(4'(g_state - GS_KW_COLOR));
      sp = word_spelling(w);
      p  = int'(g_pos);
      if (g_state > GS_KW_SQUARE || p >= sp.len()) begin
        mark_mismatch();
      end else if (c == sp[p] || (w == W_JPG && p == 2 && c == "2")) begin
        p = p + 1;
        if (p >= sp.len()) begin
          g_state = word_exit(w);
          g_pos   = '0;
        end else begin
          g_pos = 3'(p);
        end
      end else begin
        mark_mismatch();
      end
      return;
    end
    case (g_state)
      GS_START: begin
        case (g_kind)
          KIND_REGION: begin
            if (c == "f") open_word(W_FULL);
            else if (c == "s") open_word(W_SQUARE);
            else if (c == "p") open_word(W_PCT);
            else if (is_digit(c)) g_state = GS_IINT;
            else mark_mismatch();
          end
          KIND_SIZE: begin
            if (c == "^") g_state = GS_SZBODY;
            else size_choice(c);
          end
          KIND_ROT: begin
            if (c == "!") g_state = GS_FSTART;
            else if (is_digit(c)) g_state = GS_FINT;
            else mark_mismatch();
          end
          default: begin
            if (c == "c") open_word(W_COLOR);
            else if (c == "g") open_word(W_GRAY);
            else if (c == "b") open_word(W_BITONAL);
            else if (c == "d") open_word(W_DEFAULT);
            else mark_mismatch();
          end
        endcase
      end
      GS_DOT: begin
        if (c == ".") g_state = GS_FMT;
        else mark_mismatch();
      end
      GS_FMT: begin
        if (c == "j") open_word(W_JPG);
        else if (c == "t") open_word(W_TIF);
        else if (c == "p") open_word(W_PNG);
        else mark_mismatch();
      end
      GS_FSTART: begin
        if (is_digit(c)) g_state = GS_FINT;
        else mark_mismatch();
      end
      GS_FINT: begin
        if (!is_digit(c)) begin
          if (c == ".") g_state = GS_FDOT;
          else if (c == ",") list_comma(GS_FSTART);
          else mark_mismatch();
        end
      end
      GS_FDOT: begin
        if (is_digit(c)) g_state = GS_FFRAC;
        else mark_mismatch();
      end
      GS_FFRAC: begin
        if (!is_digit(c)) begin
          if (c == ",") list_comma(GS_FSTART);
          else mark_mismatch();
        end
      end
      GS_ISTART: begin
        if (is_digit(c)) g_state = GS_IINT;
        else mark_mismatch();
      end
      GS_IINT: begin
        if (!is_digit(c)) begin
          if (c == ",") list_comma(GS_ISTART);
          else mark_mismatch();
        end
      end
      GS_SZBODY: size_choice(c);
      GS_SZW0: begin
        if (is_digit(c)) g_state = GS_SZW;
        else mark_mismatch();
      end
      GS_SZH0: begin
        if (is_digit(c)) g_state = GS_SZH;
        else mark_mismatch();
      end
      GS_SZW: begin
        if (!is_digit(c)) begin
          if (c == ",") g_state = GS_SZCOMMA;
          else mark_mismatch();
        end
      end
      GS_SZCOMMA, GS_SZH: begin
        if (is_digit(c)) g_state = GS_SZH;
        else mark_mismatch();
      end
      default: mark_mismatch();
    endcase
  endtask

  // Whether the characters so far form a complete component.
  function automatic logic component_matches();
    if (g_failed) return 1'b0;
    case (g_state)
      GS_DONE:          return 1'b1;
      GS_FINT, GS_FFRAC: return g_kind != KIND_REGION || g_commas == 2'd3;
      GS_IINT:          return g_commas == 2'd3;
      GS_SZCOMMA:       return !g_confined;
      GS_SZH:           return 1'b1;
      default:          return 1'b0;
    endcase
  endfunction

  // Update the shadow state for one accepted request and queue any verdict.
  task automatic predict_request(logic [7:0] c, logic [1:0] k, logic last, logic empty);
    verdict_t v;
    if (empty && !last) return;
    if (g_state == GS_START) g_kind = kind_t'(k);
    if (!empty) recognize_char(c);
    if (last) begin
      v.ok   = component_matches();
      v.kind = g_kind;
      verdicts_due.insert(verdicts_due.size(), v);
      clear_component();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------

  // Drive one request at a falling edge and hold it until it is accepted.
  task automatic send_request(logic [7:0] c, logic [1:0] k, logic last, logic empty);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid           <= 1'b1;
    req_bus.char_code       <= c;
    req_bus.component_kind  <= k;
    req_bus.last_char       <= last;
    req_bus.empty_component <= empty;
    do @(posedge clk); while (!req_bus.ready);
    predict_request(c, k, last, empty);
    if (!(empty && !last)) chars_fed++;
  endtask

  task automatic release_channel();
    @(negedge clk);
    req_bus.valid <= 1'b0;
  endtask

  // Send the built characters as one component; stray mode sprinkles empty
  // requests, changes the kind after the opening request and may end on an
  // empty request.
  task automatic send_component(logic [1:0] k, bit stray);
    int   n;
    bit   ends_empty;
    logic [1:0] kk;
    n = spell.size();
    if (n == 0) begin
      send_request(8'($urandom_range(0, 255)), k, 1'b1, 1'b1);
      return;
    end
    ends_empty = stray && ($urandom_range(0, 5) == 0);
    for (int i = 0; i < n; i++) begin
      if (stray && $urandom_range(0, 9) == 0)
        send_request(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), 1'b0, 1'b1);
      kk = (i != 0 && stray && $urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : k;
      send_request(spell[i], kk, !ends_empty && i == n - 1, 1'b0);
    end
    if (ends_empty)
      send_request(8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)), 1'b1, 1'b1);
    spell.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Component builders
  // ---------------------------------------------------------------------------

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) spell.insert(spell.size(), s[i]);
  endtask

  task automatic add_int();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) spell.insert(spell.size(), 8'("0" + $urandom_range(0, 9)));
  endtask

  task automatic add_dec();
    add_int();
    if ($urandom_range(0, 1) == 1) begin
      add_text(".");
      add_int();
    end
  endtask

  task automatic send_text(string s, kind_t k);
    add_text(s);
    send_component(k, 1'b0);
  endtask

  task automatic build_region();
    int n;
    bit pct;
    case ($urandom_range(0, 3))
      0: add_text("full");
      1: add_text("square");
      default: begin
        pct = $urandom_range(0, 1);
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 5) : 4;
        if (pct) add_text("pct:");
        for (int i = 0; i < n; i++) begin
          if (i != 0) add_text(",");
          if (pct) add_dec();
          else add_int();
        end
      end
    endcase
  endtask

  task automatic build_size();
    if ($urandom_range(0, 2) == 0) add_text("^");
    case ($urandom_range(0, 5))
      0: add_text("max");
      1: begin add_text("pct:"); add_dec(); end
      2: begin add_int(); add_text(","); end
      3: begin add_text(","); add_int(); end
      4: begin add_int(); add_text(","); add_int(); end
      default: begin
        add_text("!");
        add_int();
        add_text(",");
        if ($urandom_range(0, 4) != 0) add_int();
      end
    endcase
  endtask

  task automatic build_rotation();
    if ($urandom_range(0, 1) == 1) add_text("!");
    add_dec();
  endtask

  task automatic build_quality_format();
    case ($urandom_range(0, 3))
      0: add_text("color");
      1: add_text("gray");
      2: add_text("bitonal");
      default: add_text("default");
    endcase
    add_text(".");
    case ($urandom_range(0, 3))
      0: add_text("jpg");
      1: add_text("tif");
      2: add_text("png");
      default: add_text("jp2");
    endcase
  endtask

  task automatic build_for(logic [1:0] k);
    case (kind_t'(k))
      KIND_REGION: build_region();
      KIND_SIZE:   build_size();
      KIND_ROT:    build_rotation();
      default:     build_quality_format();
    endcase
  endtask

  // Half the time a grammar character, otherwise any byte.
  function automatic logic [7:0] pick_char();
    string alphabet;
    alphabet = "0123456789,.:!^pctmaxfulsqrgybind2jow";
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
    return alphabet[$urandom_range(0, alphabet.len() - 1)];
  endfunction

  // Damage a built component in one place.
  task automatic corrupt_spell();
    int idx;
    int n;
    idx = (spell.size() == 0) ? 0 : $urandom_range(0, spell.size() - 1);
    case ($urandom_range(0, 4))
      0: if (spell.size() != 0) spell[idx] = pick_char();
      1: if (spell.size() != 0) spell.delete(idx);
      2: spell.insert(idx, pick_char());
      3: begin
        n = $urandom_range(1, 3);
        repeat (n) if (spell.size() != 0) void'(spell.pop_back());
      end
      default: spell.insert(spell.size(), pick_char());
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and result-side stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      ready_hold <= stall_on ? $urandom_range(0, 3) : 0;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result is_valid=%0b checked_kind=%0d", $time,
                 res_bus.is_valid, res_bus.checked_kind);
      end else begin
        verdict_seen = verdicts_due.pop_front();
        if (res_bus.is_valid !== verdict_seen.ok) begin
          errors++;
          $display("%0t: is_valid expected %0b actual %0b", $time,
                   verdict_seen.ok, res_bus.is_valid);
        end
        if (res_bus.checked_kind !== verdict_seen.kind) begin
          errors++;
          $display("%0t: checked_kind expected %0d actual %0d", $time,
                   verdict_seen.kind, res_bus.checked_kind);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold != 0) begin
      res_bus.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Valid examples across the grammar branches of each kind, plus near misses.
  task automatic test_grammar_branches();
    send_text("full", KIND_REGION);
    send_text("square", KIND_REGION);
    send_text("0,9,10,99", KIND_REGION);
    send_text("pct:1.5,0,2,3", KIND_REGION);
    send_text("1,2,3", KIND_REGION);
    send_text("max", KIND_SIZE);
    send_text("^pct:5", KIND_SIZE);
    send_text("7,", KIND_SIZE);
    send_text(",8", KIND_SIZE);
    send_text("!1,2", KIND_SIZE);
    send_text("!1,", KIND_SIZE);
    send_text("!9.5", KIND_ROT);
    send_text("0", KIND_ROT);
    send_text("color.jpg", KIND_QUALFMT);
    send_text("gray.jp2", KIND_QUALFMT);
    send_text("bitonal.png", KIND_QUALFMT);
    send_text("default.tif", KIND_QUALFMT);
    release_channel();
  endtask

  // Empty components, empty requests, kind changes and junk after a mismatch.
  task automatic test_special_cases();
    // Empty component of each kind.
    send_request(8'hFF, KIND_REGION, 1'b1, 1'b1);
    send_request(8'h00, KIND_SIZE, 1'b1, 1'b1);
    send_request(8'hA5, KIND_ROT, 1'b1, 1'b1);
    send_request(8'h5A, KIND_QUALFMT, 1'b1, 1'b1);
    // Empty requests before and inside a component carry nothing.
    send_request(8'h00, KIND_REGION, 1'b0, 1'b1);
    send_request("4", KIND_ROT, 1'b0, 1'b0);
    send_request(8'hFF, KIND_SIZE, 1'b0, 1'b1);
    send_request("5", KIND_ROT, 1'b1, 1'b0);
    // An empty request ends the component.
    send_request("m", KIND_SIZE, 1'b0, 1'b0);
    send_request("a", KIND_SIZE, 1'b0, 1'b0);
    send_request("x", KIND_SIZE, 1'b0, 1'b0);
    send_request(8'h00, KIND_SIZE, 1'b1, 1'b1);
    // The kind latched on the opening request holds to the end.
    send_request("f", KIND_REGION, 1'b0, 1'b0);
    send_request("u", KIND_QUALFMT, 1'b0, 1'b0);
    send_request("l", KIND_SIZE, 1'b0, 1'b0);
    send_request("l", KIND_ROT, 1'b1, 1'b0);
    // Characters after a mismatch are ignored, and a cut-off component fails.
    send_text("fzll", KIND_REGION);
    send_text("color.jp", KIND_QUALFMT);
    // Byte extremes.
    send_request(8'h00, KIND_REGION, 1'b0, 1'b0);
    send_request(8'hFF, KIND_REGION, 1'b1, 1'b0);
    release_channel();
  endtask

  // Mostly well-formed components with random content, some damaged or mislabeled.
  task automatic test_random_components();
    logic [1:0] k;
    int comps;
    comps = 0;
    chars_fed = 0;
    while (chars_fed < RANDOM_CHARS) begin
      if (comps % 40 == 0) begin
        pace_on  = $urandom_range(0, 2) != 0;
        stall_on = $urandom_range(0, 2) != 0;
      end
      k = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 9) == 0) build_for(2'($urandom_range(0, 3)));
      else build_for(k);
      if ($urandom_range(0, 3) == 0) corrupt_spell();
      send_component(k, $urandom_range(0, 4) == 0);
      comps++;
    end
    release_channel();
  endtask

  // Random bytes under random kinds.
  task automatic test_random_noise();
    int n;
    chars_fed = 0;
    pace_on   = 1'b1;
    stall_on  = 1'b1;
    while (chars_fed < NOISE_CHARS) begin
      n = $urandom_range(0, 6);
      repeat (n) spell.insert(spell.size(), 8'($urandom_range(0, 255)));
      send_component(2'($urandom_range(0, 3)), 1'b1);
    end
    release_channel();
  endtask

  initial begin
    rst                     = 1'b1;
    req_bus.valid           = 1'b0;
    req_bus.char_code       = '0;
    req_bus.component_kind  = '0;
    req_bus.last_char       = 1'b0;
    req_bus.empty_component = 1'b0;
    res_bus.ready           = 1'b0;
    clear_component();
    g_kind = KIND_REGION;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_grammar_branches();
    test_special_cases();
    test_random_components();
    test_random_noise();

    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
